@@ src/sbm_pkg.sv @@
// sbm_pkg: shared constants, codes and types of the sorted byte multiset
// used by the interfaces, controller, datapath and top level
package sbm_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 8;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int FIELD_CNT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   found;
        logic [FIELD_CNT_W-1:0] removed;
        logic                   prev_valid;
        logic [KEY_W-1:0]       prev_key;
        logic                   next_valid;
        logic [KEY_W-1:0]       next_key;
        logic [FIELD_CNT_W-1:0] fill;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

@@ src/sbm_if.sv @@
// sbm_in_if / sbm_out_if: valid-ready channels of the sorted byte multiset
// depends on sbm_pkg
interface sbm_in_if;
    logic                        valid;
    logic                        ready;
    logic [sbm_pkg::FUNC_W-1:0]  func;
    logic [sbm_pkg::KEY_W-1:0]   key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface sbm_out_if;
    logic                             valid;
    logic                             ready;
    logic [sbm_pkg::STATUS_W-1:0]     status;
    logic                             found;
    logic [sbm_pkg::FIELD_CNT_W-1:0]  removed;
    logic                             prev_valid;
    logic [sbm_pkg::KEY_W-1:0]        prev_key;
    logic                             next_valid;
    logic [sbm_pkg::KEY_W-1:0]        next_key;
    logic [sbm_pkg::FIELD_CNT_W-1:0]  fill;

    modport source (output valid, output status, output found, output removed,
                    output prev_valid, output prev_key, output next_valid,
                    output next_key, output fill, input ready);
    modport sink   (input valid, input status, input found, input removed,
                    input prev_valid, input prev_key, input next_valid,
                    input next_key, input fill, output ready);
endinterface

@@ src/sorted_byte_multiset_unit.sv @@
// sorted_byte_multiset_unit: top level of the sorted byte multiset
// depends on sbm_pkg, sbm_if, sbm_ctrl, sbm_dp
//
// usage
// - i_in carries one operation per beat: func (insert, delete all copies,
//   search) and an unsigned byte key; o_out returns exactly one result beat
//   per input beat, in order
// - the store holds up to 16 keys in ascending order, duplicates allowed
// - a beat is accepted in the cycle that ready is high; the 16 cells are
//   compared in parallel in that cycle, and the execute state then shifts
//   the cells and loads the result register
// - o_out.valid rises when the execute state loads the result register;
//   execute is held while the previous result still waits on the receiver
// - the next beat is accepted only after the execute state of the previous
//   one, independent of how many keys are held
// - ready is low while the controller is in execute; a result that waits on
//   a stalled receiver does not block the next input beat, which then holds
//   in execute until the result register is taken
// - reset (synchronous, active low) empties the store and drops o_out.valid
module sorted_byte_multiset_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbm_in_if.sink     i_in,
    sbm_out_if.source  o_out
);

    sbm_pkg::t_cmd    cmd;
    sbm_pkg::t_stat   stat;
    sbm_pkg::t_result res;
    logic             out_valid;

    sbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sbm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_in.func),
        .i_key       (i_in.key),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    assign o_out.valid      = out_valid;
    assign o_out.status     = res.status;
    assign o_out.found      = res.found;
    assign o_out.removed    = res.removed;
    assign o_out.prev_valid = res.prev_valid;
    assign o_out.prev_key   = res.prev_key;
    assign o_out.next_valid = res.next_valid;
    assign o_out.next_key   = res.next_key;
    assign o_out.fill       = res.fill;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken during execute");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> ##1 o_out.valid)
        else $error("no result after accepted beat");

    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == sbm_pkg::ST_FULL
        |-> o_out.fill == sbm_pkg::FIELD_CNT_W'(sbm_pkg::CAPACITY))
        else $error("full reported below capacity");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.removed != '0
        |-> o_out.status == sbm_pkg::ST_OK && o_out.found)
        else $error("removal without a present key");

endmodule

@@ src/sbm_ctrl.sv @@
// sbm_ctrl: controller of the sorted byte multiset, accept then execute
// depends on sbm_pkg
module sbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sbm_pkg::t_stat i_stat,
    output sbm_pkg::t_cmd  o_cmd
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (!i_stat.out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && !i_stat.out_busy;

endmodule

@@ src/sbm_dp.sv @@
// sbm_dp: sorted cell array with parallel compare, shift-insert and
// shift-delete, plus the result register; depends on sbm_pkg
module sbm_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbm_pkg::t_cmd               i_cmd,
    output sbm_pkg::t_stat              o_stat,
    input  logic [sbm_pkg::FUNC_W-1:0]  i_func,
    input  logic [sbm_pkg::KEY_W-1:0]   i_key,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output sbm_pkg::t_result            o_res
);

    localparam int N = sbm_pkg::CAPACITY;
    localparam int W = sbm_pkg::KEY_W;
    localparam int C = sbm_pkg::CNT_W;

    logic [N-1:0][W-1:0] r_cells;
    logic [N-1:0][W-1:0] n_cells;
    logic [C-1:0]        r_count;
    logic [C-1:0]        n_count;
    logic [sbm_pkg::FUNC_W-1:0] r_func;
    logic [W-1:0]        r_key;
    logic [N-1:0]        r_lt;
    logic [N-1:0]        r_le;
    logic [N-1:0]        r_vld;
    logic [N-1:0]        n_lt;
    logic [N-1:0]        n_le;
    logic [N-1:0]        n_vld;
    logic                r_out_valid;
    sbm_pkg::t_result    r_res;
    sbm_pkg::t_result    n_res;

    logic [N-1:0]        le_prev;
    logic [N-1:0]        prev_hot;
    logic [N-1:0]        next_hot;
    logic [N-1:0]        eq_mask;
    logic [C-1:0]        removed;
    logic                present;
    logic                full;
    logic [W-1:0]        prev_key;
    logic [W-1:0]        next_key;
    logic [N-1:0][W-1:0] ins_sh;
    logic [N-1:0][W-1:0] del_sh;
    logic [C+2:0]        del_amt;

    // parallel compare against the incoming key
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_vld[i] = C'(i) < r_count;
            n_lt[i]  = n_vld[i] && (r_cells[i] < i_key);
            n_le[i]  = n_vld[i] && (r_cells[i] <= i_key);
        end
    end

    assign le_prev  = {r_le[N-2:0], 1'b1};
    assign prev_hot = r_lt & ~{1'b0, r_lt[N-1:1]};
    assign next_hot = r_vld & ~r_le & le_prev;
    assign eq_mask  = r_le & ~r_lt;
    assign present  = |eq_mask;
    assign full     = r_count >= C'(N);

    always_comb begin
        removed = '0;
        for (int i = 0; i < N; i++) begin
            removed = removed + C'(eq_mask[i]);
        end
    end

    always_comb begin
        prev_key = '0;
        next_key = '0;
        for (int i = 0; i < N; i++) begin
            prev_key = prev_key | (prev_hot[i] ? r_cells[i] : '0);
            next_key = next_key | (next_hot[i] ? r_cells[i] : '0);
        end
    end

    assign del_amt = {removed, 3'b000};
    assign ins_sh  = r_cells << W;
    assign del_sh  = r_cells >> del_amt;

    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        n_res   = '0;
        unique case (r_func)
            sbm_pkg::FUNC_INSERT: begin
                n_res.found = present;
                if (full) begin
                    n_res.status = sbm_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < N; i++) begin
                        if (!r_le[i]) begin
                            n_cells[i] = le_prev[i] ? r_key : ins_sh[i];
                        end
                    end
                    n_count = r_count + C'(1);
                end
            end
            sbm_pkg::FUNC_DELETE: begin
                n_res.found = present;
                if (!present) begin
                    n_res.status = sbm_pkg::ST_ABSENT;
                end else begin
                    n_res.removed = sbm_pkg::FIELD_CNT_W'(removed);
                    for (int i = 0; i < N; i++) begin
                        if (!r_lt[i]) n_cells[i] = del_sh[i];
                    end
                    n_count = r_count - removed;
                end
            end
            sbm_pkg::FUNC_SEARCH: begin
                n_res.found = present;
                if (!present) begin
                    n_res.status = sbm_pkg::ST_ABSENT;
                end else begin
                    n_res.prev_valid = |prev_hot;
                    n_res.prev_key   = prev_key;
                    n_res.next_valid = |next_hot;
                    n_res.next_key   = next_key;
                end
            end
            default: begin
            end
        endcase
        n_res.fill = sbm_pkg::FIELD_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_lt   <= n_lt;
            r_le   <= n_le;
            r_vld  <= n_vld;
        end
        if (i_cmd.exec) begin
            r_cells <= n_cells;
            r_res   <= n_res;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_res           = r_res;

endmodule

@@ verif/sbm_result_checker.sv @@
// sbm_result_checker: watches the operation and result channels of the sorted byte multiset,
// keeps its own sorted key store and compares every result beat with its prediction
// depends on sbm_pkg and the channel interfaces in sbm_if
`timescale 1ns / 100ps

module sbm_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sbm_in_if    i_op,
    sbm_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_drops,
    output int   o_absent_hits
);

    logic [sbm_pkg::KEY_W-1:0] held_keys [sbm_pkg::CAPACITY];
    int                        held_count = 0;
    sbm_pkg::t_result          pending_results [$];
    int                        fail_count = 0;
    int                        checked_count = 0;
    int                        full_drops = 0;
    int                        absent_hits = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending_results.size();
    assign o_checked     = checked_count;
    assign o_full_drops  = full_drops;
    assign o_absent_hits = absent_hits;

    function automatic sbm_pkg::t_result apply_op(input logic [sbm_pkg::FUNC_W-1:0] func,
                                                  input logic [sbm_pkg::KEY_W-1:0] key);
        sbm_pkg::t_result r;
        int      lo;
        int      hi;
        int      idx;
        logic    present;
        r  = '0;
        lo = 0;
        while (lo < held_count && held_keys[lo] < key) lo++;
        hi = lo;
        while (hi < held_count && held_keys[hi] <= key) hi++;
        present = (hi > lo);
        case (func)
            sbm_pkg::FUNC_INSERT: begin
                r.found = present;
                if (held_count >= sbm_pkg::CAPACITY) begin
                    r.status = sbm_pkg::ST_FULL;
                end else begin
                    for (idx = held_count; idx > hi; idx--)
                        held_keys[idx] = held_keys[idx - 1];
                    held_keys[hi] = key;
                    held_count++;
                end
            end
            sbm_pkg::FUNC_DELETE: begin
                r.found = present;
                if (!present) begin
                    r.status = sbm_pkg::ST_ABSENT;
                end else begin
                    r.removed = sbm_pkg::FIELD_CNT_W'(hi - lo);
                    for (idx = hi; idx < held_count; idx++)
                        held_keys[lo + idx - hi] = held_keys[idx];
                    held_count -= hi - lo;
                end
            end
            sbm_pkg::FUNC_SEARCH: begin
                r.found = present;
                if (!present) begin
                    r.status = sbm_pkg::ST_ABSENT;
                end else begin
                    if (lo > 0) begin
                        r.prev_valid = 1'b1;
                        r.prev_key   = held_keys[lo - 1];
                    end
                    if (hi < held_count) begin
                        r.next_valid = 1'b1;
                        r.next_key   = held_keys[hi];
                    end
                end
            end
            default: ;
        endcase
        r.fill = sbm_pkg::FIELD_CNT_W'(held_count);
        return r;
    endfunction

    function automatic string fmt_result(input sbm_pkg::t_result r);
        return $sformatf("status=%0d found=%0b removed=%0d prev=%0b/%02h next=%0b/%02h fill=%0d",
                         r.status, r.found, r.removed, r.prev_valid, r.prev_key,
                         r.next_valid, r.next_key, r.fill);
    endfunction

    always @(posedge i_clk) begin
        sbm_pkg::t_result want;
        sbm_pkg::t_result got;
        if (!i_rst_n) begin
            held_count = 0;
            pending_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.status     = i_res.status;
                got.found      = i_res.found;
                got.removed    = i_res.removed;
                got.prev_valid = i_res.prev_valid;
                got.prev_key   = i_res.prev_key;
                got.next_valid = i_res.next_valid;
                got.next_key   = i_res.next_key;
                got.fill       = i_res.fill;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: result beat with nothing pending: %s", fmt_result(got));
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.status == sbm_pkg::ST_FULL) full_drops++;
                    if (want.status == sbm_pkg::ST_ABSENT) absent_hits++;
                    if (got.status !== want.status || got.found !== want.found ||
                        got.removed !== want.removed || got.prev_valid !== want.prev_valid ||
                        got.prev_key !== want.prev_key || got.next_valid !== want.next_valid ||
                        got.next_key !== want.next_key || got.fill !== want.fill) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("checker: result %0d mismatch\n  expected %s\n  actual   %s",
                                     checked_count, fmt_result(want), fmt_result(got));
                    end
                end
            end
            if (i_op.valid && i_op.ready)
                pending_results.push_back(apply_op(i_op.func, i_op.key));
        end
    end

endmodule

@@ verif/testbench.sv @@
// testbench: drives directed and random insert, delete and search beats into
// sorted_byte_multiset_unit with bursty input and a stalling receiver
// depends on sbm_pkg, sbm_if, the block itself and sbm_result_checker
`timescale 1ns / 100ps

module testbench;

    localparam logic [sbm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                         CYCLE_LIMIT = 200000;
    localparam int                         RANDOM_OPS  = 500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   sent_count = 0;
    int   burst_left = 0;
    int   sink_mode = 0;
    int   mode_left = 0;
    int   hold_left = 0;
    logic next_ready;
    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   full_drops;
    int   absent_hits;

    sbm_in_if  op_ch ();
    sbm_out_if res_ch ();

    sorted_byte_multiset_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    sbm_result_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_checked     (checked_count),
        .o_full_drops  (full_drops),
        .o_absent_hits (absent_hits)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: always ready, coin flips, or long on/off stretches
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (sink_mode)
            0: next_ready = 1'b1;
            1: next_ready = 1'($urandom_range(0, 1));
            default: begin
                next_ready = res_ch.ready;
                if (hold_left == 0) begin
                    next_ready = ~res_ch.ready;
                    hold_left  = $urandom_range(1, 8);
                end
                hold_left--;
            end
        endcase
        res_ch.ready <= next_ready;
    end

    task automatic send_op(input logic [sbm_pkg::FUNC_W-1:0] func,
                           input logic [sbm_pkg::KEY_W-1:0] key);
        int gap;
        op_ch.valid <= 1'b1;
        op_ch.func  <= func;
        op_ch.key   <= key;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                op_ch.valid <= 1'b0;
                op_ch.func  <= sbm_pkg::FUNC_W'($urandom);
                op_ch.key   <= sbm_pkg::KEY_W'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [sbm_pkg::KEY_W-1:0]  key_pool [6];
        logic [sbm_pkg::FUNC_W-1:0] func;
        logic [sbm_pkg::KEY_W-1:0]  key;
        int                         ins_pct;
        int                         del_pct;
        int                         pick;
        int                         n;
        int                         j;
        op_ch.valid = 1'b0;
        op_ch.func  = sbm_pkg::FUNC_INSERT;
        op_ch.key   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, unused code, extremes and duplicates
        send_op(sbm_pkg::FUNC_SEARCH, 8'h05);
        send_op(sbm_pkg::FUNC_DELETE, 8'h05);
        send_op(FUNC_UNUSED, 8'hAA);
        send_op(sbm_pkg::FUNC_INSERT, 8'h00);
        send_op(sbm_pkg::FUNC_INSERT, 8'hFF);
        for (j = 0; j < 3; j++) send_op(sbm_pkg::FUNC_INSERT, 8'h80);
        send_op(sbm_pkg::FUNC_SEARCH, 8'h80);
        send_op(sbm_pkg::FUNC_SEARCH, 8'h00);
        send_op(sbm_pkg::FUNC_SEARCH, 8'hFF);
        // fill to capacity, then drop inserts of present and absent keys
        for (j = 0; j < 11; j++) send_op(sbm_pkg::FUNC_INSERT, 8'h7F);
        send_op(sbm_pkg::FUNC_INSERT, 8'h7F);
        send_op(sbm_pkg::FUNC_INSERT, 8'h01);
        send_op(sbm_pkg::FUNC_DELETE, 8'h7F);
        send_op(sbm_pkg::FUNC_DELETE, 8'h80);

        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0) begin
                for (j = 0; j < 6; j++) begin
                    case ($urandom_range(0, 3))
                        0: key_pool[j] = 8'h00;
                        1: key_pool[j] = 8'hFF;
                        default: key_pool[j] = 8'($urandom);
                    endcase
                end
                case ($urandom_range(0, 2))
                    0: begin ins_pct = 45; del_pct = 15; end
                    1: begin ins_pct = 75; del_pct = 10; end
                    default: begin ins_pct = 30; del_pct = 35; end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                func = FUNC_UNUSED;
            else if (pick < ins_pct)
                func = sbm_pkg::FUNC_INSERT;
            else if (pick < ins_pct + del_pct)
                func = sbm_pkg::FUNC_DELETE;
            else
                func = sbm_pkg::FUNC_SEARCH;
            key = ($urandom_range(0, 3) == 0) ? 8'($urandom) : key_pool[$urandom_range(0, 5)];
            send_op(func, key);
        end
        op_ch.valid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("testbench: %0d operations sent, %0d results checked", sent_count, checked_count);
        $display("testbench: %0d inserts dropped on a full store, %0d lookups of absent keys",
                 full_drops, absent_hits);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
